// ----- design/spb_pkg.sv -----
// Shared constants, types and the palette index map for the scaled sprite blitter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package spb_pkg;

  // Sprite and palette geometry.
  localparam int FRAME_WIDTH  = 32;
  localparam int FRAME_HEIGHT = 32;
  localparam int PALETTE_SIZE = 256;
  localparam int MAX_SCALE    = 8;
  localparam int FB_LIMIT     = 4096;

  // Field widths of the channels.
  localparam int IDX_W    = 8;
  localparam int COLOR_W  = 32;
  localparam int ADDR_W   = 24;
  localparam int FB_W     = 13;
  localparam int SCALE_W  = 4;
  localparam int DEST_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths.
  localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int PAL_W  = $clog2(PALETTE_SIZE);
  localparam int PROD_W = COL_W + SCALE_W;
  localparam int POS_W  = 18;
  localparam int CRD_W  = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_FB_COLUMNS    = 3'd2,
    REG_FB_ROWS       = 3'd3,
    REG_MAGNIFY       = 3'd4,
    REG_SPRITE_ENABLE = 3'd5
  } spb_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BASE,
    ST_EMIT
  } spb_state_e;

  typedef logic [PAL_W-1:0] pal_map_t [2**IDX_W];

  // Maps an 8-bit index onto a palette entry; built once at elaboration.
  function automatic pal_map_t build_pal_map();
    pal_map_t m;
    for (int i = 0; i < 2**IDX_W; i++) begin
      m[i] = PAL_W'(i % PALETTE_SIZE);
    end
    return m;
  endfunction

  localparam pal_map_t PAL_MAP = build_pal_map();

endpackage

// ----- design/spb_if.sv -----
// Handshake channel interfaces of the scaled sprite blitter: input items,
// framebuffer writes and configuration writes. Depends on spb_pkg.
`timescale 1ns / 1ps

interface spb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [spb_pkg::IDX_W-1:0]    pixel_index;
  logic [spb_pkg::IDX_W-1:0]    entry_number;
  logic [spb_pkg::COLOR_W-1:0]  entry_color;

  modport source (output valid, func, pixel_index, entry_number, entry_color, input ready);
  modport sink (input valid, func, pixel_index, entry_number, entry_color, output ready);
endinterface

interface spb_out_if;
  logic                         valid;
  logic                         ready;
  logic [spb_pkg::ADDR_W-1:0]   write_address;
  logic [spb_pkg::COLOR_W-1:0]  write_color;
  logic                         last_write;

  modport source (output valid, write_address, write_color, last_write, input ready);
  modport sink (input valid, write_address, write_color, last_write, output ready);
endinterface

interface spb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spb_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [spb_pkg::CFG_DATA_W-1:0]  reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

// ----- design/scaled_palette_sprite_blit.sv -----
// Scaled palette sprite blitter: palette memory, sprite position counters,
// clipping setup and the framebuffer write sequencer. Depends on spb_pkg, spb_if.
//
//   port    dir   interface   word carries
//   pix_i   in    spb_in_if   palette load or one sprite pixel index
//   wr_o    out   spb_out_if  framebuffer address, color, last flag
//   cfg_i   in    spb_cfg_if  register index and data, always ready
//
// A palette load, or a transparent or disabled pixel, leaves the sequencer
// idle; a drawn pixel whose block is fully clipped returns to idle after the
// clip check. Other drawn pixels go through palette read, clip bounds and
// start address multiply, then one visible write per cycle unless the write
// port stalls. Reset clears the state, counters and config registers, not the palette.
// A stalled write port holds the sequencer; one finished word waits in the
// output register while the next item is taken.
`timescale 1ns / 1ps

module scaled_palette_sprite_blit (
  input  logic clk_i,
  input  logic rst_ni,
  spb_in_if.sink    pix_i,
  spb_out_if.source wr_o,
  spb_cfg_if.sink   cfg_i
);
  import spb_pkg::*;

  // Configuration registers.
  logic signed [DEST_W-1:0] dest_x_q, dest_y_q;
  logic [FB_W-1:0]          fb_cols_q, fb_rows_q;
  logic [SCALE_W-1:0]       magnify_q;
  logic                     enable_q;

  // Sprite position.
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;

  // Palette memory.
  logic [COLOR_W-1:0] pal_mem [PALETTE_SIZE];
  logic [COLOR_W-1:0] pal_rd_q;

  // Sequencer state and datapath.
  spb_state_e state_q, state_d;
  logic signed [POS_W-1:0] px0_q, py0_q;
  logic [SCALE_W-1:0]      scale_q;
  logic [CRD_W-1:0]        xlo_q, xhi_q, ylo_q, yhi_q;
  logic [CRD_W-1:0]        x_q, y_q;
  logic [FB_W-1:0]         rowstep_q;
  logic [ADDR_W-1:0]       addr_q;

  // Output register.
  logic               wr_valid_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic [COLOR_W-1:0] wr_color_q;
  logic               wr_last_q;

  // Control.
  logic in_ready, cfg_we, in_acc, pal_we, pix_acc, draw, slot_free, emit, last_now;

  // Derived geometry.
  logic [FB_W-1:0]         w_eff, h_eff;
  logic [SCALE_W-1:0]      scale_eff;
  logic [PROD_W-1:0]       col_prod, row_prod;
  logic signed [POS_W-1:0] px0_d, py0_d, pxe, pye, w_s, h_s;
  logic                    x_empty, y_empty;
  logic [CRD_W-1:0]        xlo_d, xhi_d, ylo_d, yhi_d;
  logic [FB_W+CRD_W-1:0]   base_prod;

  assign w_eff = (fb_cols_q > FB_W'(FB_LIMIT)) ? FB_W'(FB_LIMIT) : fb_cols_q;
  assign h_eff = (fb_rows_q > FB_W'(FB_LIMIT)) ? FB_W'(FB_LIMIT) : fb_rows_q;

  always_comb begin
    if (magnify_q == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (magnify_q > SCALE_W'(MAX_SCALE)) begin
      scale_eff = SCALE_W'(MAX_SCALE);
    end else begin
      scale_eff = magnify_q;
    end
  end

  assign col_prod = PROD_W'(col_q) * PROD_W'(scale_eff);
  assign row_prod = PROD_W'(row_q) * PROD_W'(scale_eff);
  assign px0_d = POS_W'(dest_x_q) + $signed({1'b0, (POS_W-1)'(col_prod)});
  assign py0_d = POS_W'(dest_y_q) + $signed({1'b0, (POS_W-1)'(row_prod)});

  assign cfg_we  = cfg_i.valid;
  assign in_acc  = pix_i.valid & in_ready;
  assign pal_we  = in_acc & ~pix_i.func;
  assign pix_acc = in_acc & pix_i.func;
  assign draw    = (pix_i.pixel_index != '0) & enable_q & (w_eff != '0) & (h_eff != '0);

  // Clip bounds of the scaled block.
  assign w_s = $signed({1'b0, (POS_W-1)'(w_eff)});
  assign h_s = $signed({1'b0, (POS_W-1)'(h_eff)});
  assign pxe = px0_q + $signed({1'b0, (POS_W-1)'(scale_q)}) - POS_W'(1);
  assign pye = py0_q + $signed({1'b0, (POS_W-1)'(scale_q)}) - POS_W'(1);
  assign x_empty = (pxe < 0) | (px0_q >= w_s);
  assign y_empty = (pye < 0) | (py0_q >= h_s);
  assign xlo_d = px0_q[POS_W-1] ? '0 : px0_q[CRD_W-1:0];
  assign ylo_d = py0_q[POS_W-1] ? '0 : py0_q[CRD_W-1:0];
  assign xhi_d = (pxe >= w_s) ? CRD_W'(w_eff - FB_W'(1)) : pxe[CRD_W-1:0];
  assign yhi_d = (pye >= h_s) ? CRD_W'(h_eff - FB_W'(1)) : pye[CRD_W-1:0];

  assign base_prod = (FB_W+CRD_W)'(ylo_q) * (FB_W+CRD_W)'(w_eff);

  assign slot_free = ~wr_valid_q | wr_o.ready;
  assign last_now  = (x_q == xhi_q) & (y_q == yhi_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pix_acc && draw) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = (x_empty || y_empty) ? ST_IDLE : ST_BASE;
      end
      ST_BASE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && last_now) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    emit     = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_EMIT:  emit = slot_free;
      default: begin
        in_ready = 1'b0;
        emit     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers and sprite position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q  <= '0;
      dest_y_q  <= '0;
      fb_cols_q <= '0;
      fb_rows_q <= '0;
      magnify_q <= SCALE_W'(1);
      enable_q  <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (cfg_we) begin
      case (cfg_i.reg_index)
        REG_DEST_X: begin
          dest_x_q <= $signed(cfg_i.reg_data[DEST_W-1:0]);
          col_q <= '0;
          row_q <= '0;
        end
        REG_DEST_Y: begin
          dest_y_q <= $signed(cfg_i.reg_data[DEST_W-1:0]);
          col_q <= '0;
          row_q <= '0;
        end
        REG_FB_COLUMNS: begin
          fb_cols_q <= cfg_i.reg_data[FB_W-1:0];
          col_q <= '0;
          row_q <= '0;
        end
        REG_FB_ROWS: begin
          fb_rows_q <= cfg_i.reg_data[FB_W-1:0];
          col_q <= '0;
          row_q <= '0;
        end
        REG_MAGNIFY: begin
          magnify_q <= cfg_i.reg_data[SCALE_W-1:0];
          col_q <= '0;
          row_q <= '0;
        end
        REG_SPRITE_ENABLE: begin
          enable_q <= cfg_i.reg_data[0];
          col_q <= '0;
          row_q <= '0;
        end
        default: begin
          col_q <= col_q;
        end
      endcase
    end else if (pix_acc) begin
      if (col_q == COL_W'(FRAME_WIDTH - 1)) begin
        col_q <= '0;
        row_q <= (row_q == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[PAL_MAP[pix_i.entry_number]] <= pix_i.entry_color;
    end
    if (pix_acc) begin
      pal_rd_q <= pal_mem[PAL_MAP[pix_i.pixel_index]];
    end
  end

  // Block geometry and write walk.
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      px0_q   <= px0_d;
      py0_q   <= py0_d;
      scale_q <= scale_eff;
    end
    if (state_q == ST_SETUP) begin
      xlo_q <= xlo_d;
      xhi_q <= xhi_d;
      ylo_q <= ylo_d;
      yhi_q <= yhi_d;
    end
    if (state_q == ST_BASE) begin
      addr_q    <= ADDR_W'(base_prod) + ADDR_W'(xlo_q);
      rowstep_q <= w_eff - FB_W'(xhi_q - xlo_q);
      x_q       <= xlo_q;
      y_q       <= ylo_q;
    end else if (emit) begin
      if (x_q == xhi_q) begin
        x_q    <= xlo_q;
        y_q    <= y_q + CRD_W'(1);
        addr_q <= addr_q + ADDR_W'(rowstep_q);
      end else begin
        x_q    <= x_q + CRD_W'(1);
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else if (emit) begin
      wr_valid_q <= 1'b1;
    end else if (wr_o.ready) begin
      wr_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      wr_addr_q  <= addr_q;
      wr_color_q <= pal_rd_q;
      wr_last_q  <= last_now;
    end
  end

  assign pix_i.ready      = in_ready;
  assign wr_o.valid         = wr_valid_q;
  assign wr_o.write_address = wr_addr_q;
  assign wr_o.write_color   = wr_color_q;
  assign wr_o.last_write    = wr_last_q;

endmodule

// ----- tb/scaled_palette_sprite_blit_test.sv -----
// Self-checking testbench for the scaled palette sprite blitter: directed and random
// palette loads, sprite pixels and register writes, checked against a built-in predictor.
// Depends on spb_pkg, the spb_if channel interfaces and scaled_palette_sprite_blit.
`timescale 1ns / 1ps

module scaled_palette_sprite_blit_test;
  import spb_pkg::*;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic                func;
    logic [IDX_W-1:0]    pixel_index;
    logic [IDX_W-1:0]    entry_number;
    logic [COLOR_W-1:0]  entry_color;
  } blit_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } fb_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  spb_in_if  pix ();
  spb_out_if wr ();
  spb_cfg_if cfg ();

  scaled_palette_sprite_blit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .wr_o   (wr),
    .cfg_i  (cfg)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: palette, sprite position and the register file.
  logic [COLOR_W-1:0]      palette_mem [PALETTE_SIZE];
  int                      sprite_col;
  int                      sprite_row;
  logic signed [DEST_W-1:0] dest_x_reg;
  logic signed [DEST_W-1:0] dest_y_reg;
  logic [FB_W-1:0]         fb_cols_reg;
  logic [FB_W-1:0]         fb_rows_reg;
  logic [SCALE_W-1:0]      magnify_reg;
  logic                    enable_reg;

  blit_item_t  blit_items [$];
  fb_write_t   pending_writes [$];
  fb_write_t   oldest_write;
  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          pressure_arm;
  int          hold_left;
  bit          hold_used;
  int          cycle_count;

  // Stimulus-side record of nonzero palette entries that have been loaded.
  bit          entry_loaded [PALETTE_SIZE];
  logic [IDX_W-1:0] loaded_list [$];

  task automatic predict_fb_writes(input blit_item_t it);
    int w, h, s, py, px, col, row, n;
    logic [COLOR_W-1:0] color;
    fb_write_t one;
    if (it.func == FUNC_LOAD) begin
      palette_mem[it.entry_number % PALETTE_SIZE] = it.entry_color;
      return;
    end
    col = sprite_col;
    row = sprite_row;
    w = (fb_cols_reg > FB_LIMIT) ? FB_LIMIT : fb_cols_reg;
    h = (fb_rows_reg > FB_LIMIT) ? FB_LIMIT : fb_rows_reg;
    s = (magnify_reg == 0) ? 1 : magnify_reg;
    if (s > MAX_SCALE) s = MAX_SCALE;
    sprite_col++;
    if (sprite_col >= FRAME_WIDTH) begin
      sprite_col = 0;
      sprite_row++;
      if (sprite_row >= FRAME_HEIGHT) sprite_row = 0;
    end
    if (it.pixel_index == 0 || !enable_reg || w == 0 || h == 0) return;
    color = palette_mem[it.pixel_index % PALETTE_SIZE];
    n = 0;
    for (int sy = 0; sy < s; sy++) begin
      py = int'(dest_y_reg) + row * s + sy;
      if (py < 0 || py >= h) continue;
      for (int sx = 0; sx < s; sx++) begin
        px = int'(dest_x_reg) + col * s + sx;
        if (px < 0 || px >= w) continue;
        one.address = ADDR_W'(py * w + px);
        one.color = color;
        one.last = 1'b0;
        pending_writes.push_back(one);
        n++;
      end
    end
    if (n > 0) pending_writes[pending_writes.size() - 1].last = 1'b1;
  endtask

  // Pixel channel driver; an offered word stays put until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.func <= FUNC_LOAD;
      pix.pixel_index <= '0;
      pix.entry_number <= '0;
      pix.entry_color <= '0;
    end else begin
      if (pix.valid && pix.ready) predict_fb_writes(blit_items.pop_front());
      if (!(pix.valid && !pix.ready)) begin
        if (blit_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pix.valid <= 1'b1;
          pix.func <= blit_items[0].func;
          pix.pixel_index <= blit_items[0].pixel_index;
          pix.entry_number <= blit_items[0].entry_number;
          pix.entry_color <= blit_items[0].entry_color;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // One long write-port stall, started by the first pixel word taken once armed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_arm && !hold_used && pix.valid && pix.ready) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Write port monitor and ready generation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr.ready <= 1'b0;
    end else begin
      if (wr.valid && wr.ready) begin
        if (pending_writes.size() == 0) begin
          $error("write_address: unexpected word, got %0h", wr.write_address);
          fail_count++;
        end else begin
          oldest_write = pending_writes.pop_front();
          if (wr.write_address !== oldest_write.address) begin
            $error("write_address: expected %0h, got %0h", oldest_write.address,
                   wr.write_address);
            fail_count++;
          end
          if (wr.write_color !== oldest_write.color) begin
            $error("write_color: expected %0h, got %0h", oldest_write.color, wr.write_color);
            fail_count++;
          end
          if (wr.last_write !== oldest_write.last) begin
            $error("last_write: expected %0b, got %0b", oldest_write.last, wr.last_write);
            fail_count++;
          end
        end
      end
      wr.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[scaled_palette_sprite_blit] ERROR");
      $finish;
    end
  end

  task automatic use_idle_mode(input int mode);
    case (mode)
      1: begin send_idle_pct = 80; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 80; end
      3: begin send_idle_pct = 7; recv_stall_pct = 7; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic queue_load(input logic [IDX_W-1:0] entry, input logic [COLOR_W-1:0] color);
    blit_items.push_back('{func: FUNC_LOAD, pixel_index: IDX_W'($urandom_range(255)),
                           entry_number: entry, entry_color: color});
    if (entry != 0 && !entry_loaded[entry]) begin
      entry_loaded[entry] = 1'b1;
      loaded_list.push_back(entry);
    end
  endtask

  task automatic queue_pixel(input logic [IDX_W-1:0] index);
    blit_items.push_back('{func: FUNC_PIXEL, pixel_index: index,
                           entry_number: IDX_W'($urandom_range(255)),
                           entry_color: $urandom()});
  endtask

  function automatic logic [IDX_W-1:0] pick_opaque();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // Waits until every word is taken and every write has come, then lets the
  // sequencer finish any pixel that draws nothing.
  task automatic wait_idle();
    do @(negedge clk_i); while (blit_items.size() != 0 || pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Called at a rising edge; returns at the edge where the write is taken.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.reg_data <= data;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_DEST_X:        dest_x_reg = data;
      REG_DEST_Y:        dest_y_reg = data;
      REG_FB_COLUMNS:    fb_cols_reg = data[FB_W-1:0];
      REG_FB_ROWS:       fb_rows_reg = data[FB_W-1:0];
      REG_MAGNIFY:       magnify_reg = data[SCALE_W-1:0];
      REG_SPRITE_ENABLE: enable_reg = data[0];
      default:           return;
    endcase
    sprite_col = 0;
    sprite_row = 0;
  endtask

  task automatic cfg_setup(input logic [CFG_DATA_W-1:0] dx, input logic [CFG_DATA_W-1:0] dy,
                           input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] mag, input logic [CFG_DATA_W-1:0] en);
    @(posedge clk_i);
    cfg_write(REG_DEST_X, dx);
    cfg_write(REG_DEST_Y, dy);
    cfg_write(REG_FB_COLUMNS, cols);
    cfg_write(REG_FB_ROWS, rows);
    cfg_write(REG_MAGNIFY, mag);
    cfg_write(REG_SPRITE_ENABLE, en);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_dest();
    if ($urandom_range(99) < 15) return CFG_DATA_W'($urandom_range(16'hFFFF));
    return CFG_DATA_W'($urandom_range(80) - 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_extent();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return CFG_DATA_W'($urandom_range(16'hFFFF));
    return CFG_DATA_W'($urandom_range(120, 1));
  endfunction

  initial begin
    fail_count = 0;
    cycle_count = 0;
    pressure_arm = 1'b0;
    sprite_col = 0;
    sprite_row = 0;
    dest_x_reg = '0;
    dest_y_reg = '0;
    fb_cols_reg = '0;
    fb_rows_reg = '0;
    magnify_reg = SCALE_W'(1);
    enable_reg = 1'b0;
    use_idle_mode(0);
    cfg.valid <= 1'b0;
    cfg.reg_index <= '0;
    cfg.reg_data <= '0;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Palette loads at the field extremes, then a pixel with drawing still disabled.
    queue_load(8'h00, 32'h0000_0000);
    queue_load(8'hFF, 32'hFFFF_FFFF);
    queue_load(8'h01, 32'h1234_5678);
    queue_load(8'h80, 32'h8000_0001);
    queue_load(8'h55, 32'hAAAA_5555);
    queue_load(8'hAA, 32'h5555_AAAA);
    queue_pixel(8'h01);
    wait_idle();

    // Scale zero acts as one; transparent pixel; reloaded entry is used at once.
    cfg_setup(16'd0, 16'd0, 16'd64, 16'd48, 16'd0, 16'd1);
    queue_pixel(8'hFF);
    queue_pixel(8'h00);
    queue_pixel(8'h01);
    queue_pixel(8'h80);
    queue_load(8'h01, 32'hCAFE_0F0F);
    queue_pixel(8'h01);
    wait_idle();

    // Scale above the maximum saturates; clipping on the left, top and right.
    cfg_setup(16'hFFFB, 16'hFFFD, 16'd10, 16'd10, 16'd15, 16'd1);
    queue_pixel(8'h55);
    queue_pixel(8'hAA);
    queue_pixel(8'hFF);
    wait_idle();

    // Extreme destinations leave the sprite entirely off the framebuffer.
    cfg_setup(16'h8000, 16'h7FFF, 16'd64, 16'd64, 16'd2, 16'd1);
    queue_pixel(8'h01);
    wait_idle();

    // Oversized framebuffer saturates; writes reach the top of the address range.
    // Writes to indexes past the register list must not move the sprite position.
    cfg_setup(16'd4090, 16'd4090, 16'hFFFF, 16'h1000, 16'd8, 16'd1);
    queue_pixel(8'h01);
    queue_pixel(8'h80);
    wait_idle();
    @(posedge clk_i);
    cfg_write(REG_RESERVED_LO, 16'hFFFF);
    cfg.valid <= 1'b0;
    queue_pixel(8'hFF);
    wait_idle();
    @(posedge clk_i);
    cfg_write(REG_RESERVED_HI, 16'h0000);
    cfg.valid <= 1'b0;
    queue_pixel(8'h55);
    wait_idle();

    // A zero framebuffer dimension suppresses drawing.
    cfg_setup(16'd0, 16'd0, 16'd20, 16'd0, 16'd1, 16'd1);
    queue_pixel(8'hAA);
    wait_idle();
    cfg_setup(16'd0, 16'd0, 16'd0, 16'd20, 16'd1, 16'd1);
    queue_pixel(8'hAA);
    wait_idle();

    // Full-size blocks with the write port held off long enough to back up the input.
    cfg_setup(16'd0, 16'd0, 16'd256, 16'd256, 16'd8, 16'd1);
    pressure_arm = 1'b1;
    for (int k = 0; k < 20; k++) queue_pixel(pick_opaque());
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      use_idle_mode(p % 4);
      cfg_setup(random_dest(), random_dest(), random_extent(), random_extent(),
                ($urandom_range(99) < 60) ? CFG_DATA_W'($urandom_range(4))
                                          : CFG_DATA_W'($urandom_range(15)),
                ($urandom_range(99) < 90) ? 16'd1 : 16'd0);
      for (int k = 0; k < 13; k++) begin
        if ($urandom_range(99) < 20) begin
          queue_load(IDX_W'($urandom_range(255)), $urandom());
        end else if ($urandom_range(99) < 15) begin
          queue_pixel(8'h00);
        end else begin
          queue_pixel(pick_opaque());
        end
      end
      wait_idle();
    end

    // More than one sprite row, so the column counter wraps and the row advances.
    use_idle_mode(3);
    cfg_setup(16'd0, 16'd0, 16'd40, 16'd40, 16'd1, 16'd1);
    for (int k = 0; k < FRAME_WIDTH + 8; k++) begin
      queue_pixel((k % 29 == 0) ? pick_opaque() : 8'h00);
    end
    wait_idle();

    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("[scaled_palette_sprite_blit] OK");
    end else begin
      $display("[scaled_palette_sprite_blit] ERROR");
    end
    $finish;
  end

endmodule
